@@ src/lkvc_pkg.sv @@
// Package for the LRU key-value cache: shared constants, payload structs,
// controller state type and the command/status bundles between modules.
// No dependencies.
package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PASS,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic pass;
        logic fin;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic is_lookup;
        logic found;
        logic out_free;
    } t_sts;

endpackage

@@ src/lkvc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lkvc_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lkvc_datapath.sv @@
// Datapath of the LRU key-value cache: key, value and rank memories, the
// entry walk counter, match and victim tracking, and the result register.
// Depends on lkvc_pkg and lkvc_ram.
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lkvc_pkg::t_cmd           i_cmd,
    output lkvc_pkg::t_sts           o_sts,
    input  lkvc_pkg::t_req           i_in_data,
    input  logic                     i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output lkvc_pkg::t_rsp           o_out_data
);

    import lkvc_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (UW > CAP_W) ? UW : CAP_W;
    localparam logic [CMPW-1:0] ENT_C = CMPW'(ENTRIES);

    t_req             r_req;
    logic [CAP_W-1:0] r_cap;
    logic [UW-1:0]    r_used;
    logic [UW-1:0]    r_cnt;
    logic             r_pv;
    logic [IW-1:0]    r_pidx;
    logic             r_found;
    logic [IW-1:0]    r_fidx;
    logic [IW-1:0]    r_frank;
    logic [IW-1:0]    r_vidx;
    logic [IW-1:0]    r_vrank;
    logic [IW-1:0]    r_tidx;
    logic [IW-1:0]    r_told;
    logic             r_new;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;
    logic [IW-1:0]    rank_rd;

    logic             c_issue;
    logic             c_is_ins;
    logic             c_ent_we;
    logic             c_rank_we;
    logic [IW-1:0]    c_rank_waddr;
    logic [IW-1:0]    c_rank_wdata;
    logic [CMPW-1:0]  c_cap;
    logic             c_room;

    assign c_is_ins = (r_req.op == OP_INSERT);
    assign c_ent_we = i_cmd.fin && c_is_ins;
    assign c_issue  = (i_cmd.scan || i_cmd.pass) && (r_cnt != r_used);

    // Memories: keys and ranks are walked by the counter, values read at the match
    lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (c_ent_we),
        .i_waddr (r_tidx),
        .i_wdata (r_req.key),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (key_rd)
    );

    lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (c_ent_we),
        .i_waddr (r_tidx),
        .i_wdata (r_req.value),
        .i_raddr (r_fidx),
        .o_rdata (val_rd)
    );

    lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (c_rank_we),
        .i_waddr (c_rank_waddr),
        .i_wdata (c_rank_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rank_rd)
    );

    // Effective capacity: zero acts as one, clamp to the entry count
    always_comb begin
        if (r_cap == '0) begin
            c_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > ENT_C) begin
            c_cap = ENT_C;
        end else begin
            c_cap = CMPW'(r_cap);
        end
    end

    assign c_room = (CMPW'(r_used) < c_cap);

    // Rank writes: age entries newer than the touched one, then zero the touched one
    always_comb begin
        c_rank_we    = 1'b0;
        c_rank_waddr = r_pidx;
        c_rank_wdata = rank_rd + IW'(1);
        if (i_cmd.pass && r_pv && (rank_rd < r_told)) begin
            c_rank_we = 1'b1;
        end else if (i_cmd.fin && (c_is_ins || r_found)) begin
            c_rank_we    = 1'b1;
            c_rank_waddr = r_tidx;
            c_rank_wdata = '0;
        end
    end

    // Capture the request transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    // Capacity register and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_used <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.fin && c_is_ins && r_new) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    // Walk counter over the filled entries, one read issued per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.load || i_cmd.decide) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.scan || i_cmd.pass) begin
            if (c_issue) begin
                r_cnt <= r_cnt + UW'(1);
            end
            r_pv <= c_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_issue) begin
            r_pidx <= r_cnt[IW-1:0];
        end
    end

    // Track the first key match and the least recent entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= 1'b0;
            r_vidx  <= '0;
            r_vrank <= '0;
        end else if (i_cmd.scan && r_pv) begin
            if ((key_rd == r_req.key) && !r_found) begin
                r_found <= 1'b1;
                r_fidx  <= r_pidx;
                r_frank <= rank_rd;
            end
            if (rank_rd > r_vrank) begin
                r_vidx  <= r_pidx;
                r_vrank <= rank_rd;
            end
        end
    end

    // Pick the target entry and its old rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (r_found) begin
                r_tidx <= r_fidx;
                r_told <= r_frank;
                r_new  <= 1'b0;
            end else if (c_room) begin
                r_tidx <= r_used[IW-1:0];
                r_told <= r_used[IW-1:0];
                r_new  <= 1'b1;
            end else begin
                r_tidx <= r_vidx;
                r_told <= r_vrank;
                r_new  <= 1'b0;
            end
        end
    end

    // Result register: load on lookup finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin && !c_is_ins) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && !c_is_ins) begin
            r_out.hit        <= r_found;
            r_out.read_value <= r_found ? val_rd : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_sts.walk_done = (r_cnt == r_used) && !r_pv;
    assign o_sts.is_lookup = !c_is_ins;
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_used) <= ENT_C)
        else $error("fill count exceeds entry count");

    a_used_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.fin && c_is_ins && r_new) |=> (r_used == $past(r_used)))
        else $error("fill count changed without a new-entry insert");

    a_rank_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pass && c_rank_we) |-> (c_rank_wdata <= r_told))
        else $error("aged rank passes the touched entry's old rank");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |-> (r_out.read_value == '0))
        else $error("miss result carries a nonzero value");

    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && !c_is_ins) |-> (!r_out_valid || i_out_ready))
        else $error("lookup result overwrites an untaken result");
`endif

endmodule

@@ src/lkvc_ctrl.sv @@
// Controller of the LRU key-value cache: sequences scan, decide, rank pass (skipped
// on a lookup miss) and finish for one request at a time. Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lkvc_pkg::t_sts i_sts,
    output lkvc_pkg::t_cmd o_cmd
);

    import lkvc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.walk_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.is_lookup && !i_sts.found) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                if (i_sts.walk_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_sts.is_lookup || i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_PASS: begin
                o_cmd.pass = 1'b1;
            end
            ST_FIN: begin
                o_cmd.fin = !i_sts.is_lookup || i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ src/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Requests are handled one at a time: a new one is accepted only after the last one
// has finished. The key and rank walks read one filled entry per cycle; a lookup
// miss skips the rank walk.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath.
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lkvc_pkg::t_req             i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lkvc_pkg::t_rsp             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata
);

    import lkvc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and compare
    lkvc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
